/* rtl/core/nsrl_pkg.sv */
package nsrl_pkg;

  localparam int COORD_W   = 24;
  localparam int TEX_W     = 17;
  localparam int CORNER_W  = 23;
  localparam int TSIZE_W   = 14;
  localparam int EXT_W     = 24;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CMP_W     = ((COORD_W > EXT_W) ? COORD_W : EXT_W) + 2;
  localparam int DIV_STEPS = EXT_W;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [TEX_W-1:0] ONE_Q16  = TEX_W'(65536);
  localparam logic [TEX_W-1:0] HALF_Q16 = TEX_W'(32768);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = CFG_IDX_W'(5);

  localparam logic [TEX_W-1:0]   CENTER_RST = HALF_Q16;
  localparam logic [TSIZE_W-1:0] TSIZE_RST  = TSIZE_W'(64);

  typedef struct packed {
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_bottom;
    logic signed [COORD_W-1:0] box_right;
    logic signed [COORD_W-1:0] box_top;
  } box_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] quad_x0;
    logic signed [COORD_W-1:0] quad_y0;
    logic signed [COORD_W-1:0] quad_x1;
    logic signed [COORD_W-1:0] quad_y1;
    logic [TEX_W-1:0]          tex_u0;
    logic [TEX_W-1:0]          tex_v0;
    logic [TEX_W-1:0]          tex_u1;
    logic [TEX_W-1:0]          tex_v1;
    logic                      last_quad;
  } quad_t;

  // one classified box: stripe boundaries per axis plus texture split
  typedef struct packed {
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] x_hi;
    logic signed [COORD_W-1:0] y_lo;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] y_b;
    logic signed [COORD_W-1:0] y_hi;
    logic                      inner_h;
    logic                      inner_v;
    logic [TEX_W-1:0]          tu;
    logic [TEX_W-1:0]          tv;
  } split_t;

  typedef struct packed {
    logic                start;
    logic [CORNER_W-1:0] corner;
    logic [TEX_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [EXT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_START_X,
    EX_WAIT_X,
    EX_START_Y,
    EX_WAIT_Y
  } ext_state_t;

  typedef enum logic [3:0] {
    K_BL,
    K_TL,
    K_TR,
    K_BR,
    K_LE,
    K_RE,
    K_BE,
    K_TE,
    K_CE
  } kind_t;

endpackage

/* rtl/core/nsrl_div.sv */
module nsrl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nsrl_pkg::div_req_t req,
  output nsrl_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(nsrl_pkg::DIV_STEPS);
  localparam int LOW_W = nsrl_pkg::EXT_W;
  localparam int REM_W = nsrl_pkg::TEX_W;

  logic [REM_W-1:0] rem_r;
  logic [LOW_W-1:0] quo_r;
  logic [REM_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[LOW_W-1]};
    ge    = trial >= {1'b0, dsr_r};
    diff  = trial - {1'b0, dsr_r};
  end

  // dividend is corner * 65536; its top bits stay below the divisor (>= 0.5 in Q1.16)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(nsrl_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= REM_W'(req.corner >> (LOW_W - 16));
      quo_r <= LOW_W'({req.corner, 16'b0});
      dsr_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_r <= {quo_r[LOW_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* rtl/core/nsrl_front.sv */
module nsrl_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [nsrl_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [nsrl_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  push,
  output logic                                  full,
  input  nsrl_pkg::box_t                        in_box,
  output nsrl_pkg::div_req_t                    div_req,
  input  nsrl_pkg::div_rsp_t                    div_rsp,
  output logic                                  q_push,
  input  logic                                  q_full,
  output nsrl_pkg::split_t                      q_data
);

  localparam int CW = nsrl_pkg::COORD_W;
  localparam int XW = nsrl_pkg::EXT_W;
  localparam int KW = nsrl_pkg::CMP_W;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic                 inner;
  } axis_t;

  logic [nsrl_pkg::TEX_W-1:0]    cx_r, cy_r;
  logic [nsrl_pkg::CORNER_W-1:0] csx_r, csy_r;
  logic [nsrl_pkg::TSIZE_W-1:0]  tw_r, th_r;
  logic [XW-1:0]                 ext_x_r, ext_y_r;

  nsrl_pkg::ext_state_t st_r, st_nxt;

  logic [nsrl_pkg::TEX_W-1:0] cxc, cyc, mx, my;
  axis_t                      ax, ay;

  function automatic axis_t split_axis(input logic signed [CW-1:0] lo,
                                       input logic signed [CW-1:0] hi,
                                       input logic [XW-1:0] ext);
    axis_t                r;
    logic signed [KW-1:0] sz;
    logic signed [KW-1:0] ex;
    logic signed [CW:0]   sum;
    logic [XW-1:0]        half;
    sz   = KW'(hi) - KW'(lo);
    ex   = KW'(signed'({1'b0, ext}));
    sum  = (CW+1)'(lo) + (CW+1)'(hi);
    half = ext >> 1;
    if (ex > sz) begin
      // corners overlap: stripes meet at the box middle
      r.a     = CW'(sum >>> 1);
      r.b     = CW'(sum >>> 1);
      r.inner = 1'b0;
    end else begin
      r.a     = lo + CW'(half);
      r.b     = hi - CW'(half);
      r.inner = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    cxc = (cx_r > nsrl_pkg::ONE_Q16) ? nsrl_pkg::ONE_Q16 : cx_r;
    cyc = (cy_r > nsrl_pkg::ONE_Q16) ? nsrl_pkg::ONE_Q16 : cy_r;
    mx  = (cxc > nsrl_pkg::HALF_Q16) ? cxc : nsrl_pkg::ONE_Q16 - cxc;
    my  = (cyc > nsrl_pkg::HALF_Q16) ? cyc : nsrl_pkg::ONE_Q16 - cyc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= nsrl_pkg::CENTER_RST;
      cy_r  <= nsrl_pkg::CENTER_RST;
      csx_r <= '0;
      csy_r <= '0;
      tw_r  <= nsrl_pkg::TSIZE_RST;
      th_r  <= nsrl_pkg::TSIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        nsrl_pkg::REG_CENTER_X:   cx_r  <= nsrl_pkg::TEX_W'(cfg_data);
        nsrl_pkg::REG_CENTER_Y:   cy_r  <= nsrl_pkg::TEX_W'(cfg_data);
        nsrl_pkg::REG_CORNER_X:   csx_r <= nsrl_pkg::CORNER_W'(cfg_data);
        nsrl_pkg::REG_CORNER_Y:   csy_r <= nsrl_pkg::CORNER_W'(cfg_data);
        nsrl_pkg::REG_TEX_WIDTH:  tw_r  <= nsrl_pkg::TSIZE_W'(cfg_data);
        nsrl_pkg::REG_TEX_HEIGHT: th_r  <= nsrl_pkg::TSIZE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // corner extents are recomputed after reset and after every register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nsrl_pkg::EX_START_X;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt          = st_r;
    div_req.start   = 1'b0;
    div_req.corner  = csx_r;
    div_req.divisor = mx;
    unique case (st_r)
      nsrl_pkg::EX_IDLE: ;
      nsrl_pkg::EX_START_X: begin
        div_req.start = 1'b1;
        st_nxt        = nsrl_pkg::EX_WAIT_X;
      end
      nsrl_pkg::EX_WAIT_X: begin
        if (div_rsp.done) st_nxt = nsrl_pkg::EX_START_Y;
      end
      nsrl_pkg::EX_START_Y: begin
        div_req.start   = 1'b1;
        div_req.corner  = csy_r;
        div_req.divisor = my;
        st_nxt          = nsrl_pkg::EX_WAIT_Y;
      end
      nsrl_pkg::EX_WAIT_Y: begin
        if (div_rsp.done) st_nxt = nsrl_pkg::EX_IDLE;
      end
      default: st_nxt = nsrl_pkg::EX_START_X;
    endcase
    if (cfg_we) st_nxt = nsrl_pkg::EX_START_X;
  end

  always_ff @(posedge clk) begin
    if (st_r == nsrl_pkg::EX_WAIT_X && div_rsp.done) begin
      ext_x_r <= (csx_r == '0) ? XW'({tw_r, 8'b0}) : div_rsp.quot;
    end
    if (st_r == nsrl_pkg::EX_WAIT_Y && div_rsp.done) begin
      ext_y_r <= (csy_r == '0) ? XW'({th_r, 8'b0}) : div_rsp.quot;
    end
  end

  always_comb begin
    ax = split_axis(in_box.box_left, in_box.box_right, ext_x_r);
    ay = split_axis(in_box.box_bottom, in_box.box_top, ext_y_r);
  end

  assign full   = (st_r != nsrl_pkg::EX_IDLE) || q_full;
  assign q_push = push && !full;

  always_comb begin
    q_data.x_lo    = in_box.box_left;
    q_data.x_a     = ax.a;
    q_data.x_b     = ax.b;
    q_data.x_hi    = in_box.box_right;
    q_data.y_lo    = in_box.box_bottom;
    q_data.y_a     = ay.a;
    q_data.y_b     = ay.b;
    q_data.y_hi    = in_box.box_top;
    q_data.inner_h = ay.inner;
    q_data.inner_v = ax.inner;
    q_data.tu      = cxc;
    q_data.tv      = nsrl_pkg::ONE_Q16 - cyc;
  end

endmodule

/* rtl/core/nsrl_queue.sv */
module nsrl_queue #(
  parameter int DEPTH = nsrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  nsrl_pkg::split_t  wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output nsrl_pkg::split_t  rd_data,
  output logic              q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nsrl_pkg::split_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = cnt_r == CNT_W'(DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/nsrl_back.sv */
module nsrl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  nsrl_pkg::split_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output nsrl_pkg::quad_t  out_quad
);

  localparam logic [nsrl_pkg::TEX_W-1:0] ZERO_Q16 = '0;

  nsrl_pkg::kind_t  kind_r, kind_nxt;
  nsrl_pkg::quad_t  quad_r, quad;
  logic             valid_r;
  logic             advance;
  logic             last;

  assign advance = !q_empty && (!valid_r || pop);

  // walk the quads of the head box: corners, side edges, bottom/top edges, center
  always_comb begin
    kind_nxt = kind_r;
    last     = 1'b0;
    quad     = '0;
    unique case (kind_r)
      nsrl_pkg::K_BL: begin
        quad = {q_data.x_lo, q_data.y_lo, q_data.x_a, q_data.y_a,
                ZERO_Q16, nsrl_pkg::ONE_Q16, q_data.tu, q_data.tv, 1'b0};
        kind_nxt = nsrl_pkg::K_TL;
      end
      nsrl_pkg::K_TL: begin
        quad = {q_data.x_lo, q_data.y_b, q_data.x_a, q_data.y_hi,
                ZERO_Q16, q_data.tv, q_data.tu, ZERO_Q16, 1'b0};
        kind_nxt = nsrl_pkg::K_TR;
      end
      nsrl_pkg::K_TR: begin
        quad = {q_data.x_b, q_data.y_b, q_data.x_hi, q_data.y_hi,
                q_data.tu, q_data.tv, nsrl_pkg::ONE_Q16, ZERO_Q16, 1'b0};
        kind_nxt = nsrl_pkg::K_BR;
      end
      nsrl_pkg::K_BR: begin
        quad = {q_data.x_b, q_data.y_lo, q_data.x_hi, q_data.y_a,
                q_data.tu, nsrl_pkg::ONE_Q16, nsrl_pkg::ONE_Q16, q_data.tv, 1'b0};
        if (q_data.inner_h) kind_nxt = nsrl_pkg::K_LE;
        else if (q_data.inner_v) kind_nxt = nsrl_pkg::K_BE;
        else last = 1'b1;
      end
      nsrl_pkg::K_LE: begin
        quad = {q_data.x_lo, q_data.y_a, q_data.x_a, q_data.y_b,
                ZERO_Q16, q_data.tv, q_data.tu, q_data.tv, 1'b0};
        kind_nxt = nsrl_pkg::K_RE;
      end
      nsrl_pkg::K_RE: begin
        quad = {q_data.x_b, q_data.y_a, q_data.x_hi, q_data.y_b,
                q_data.tu, q_data.tv, nsrl_pkg::ONE_Q16, q_data.tv, 1'b0};
        if (q_data.inner_v) kind_nxt = nsrl_pkg::K_BE;
        else last = 1'b1;
      end
      nsrl_pkg::K_BE: begin
        quad = {q_data.x_a, q_data.y_lo, q_data.x_b, q_data.y_a,
                q_data.tu, nsrl_pkg::ONE_Q16, q_data.tu, q_data.tv, 1'b0};
        kind_nxt = nsrl_pkg::K_TE;
      end
      nsrl_pkg::K_TE: begin
        quad = {q_data.x_a, q_data.y_b, q_data.x_b, q_data.y_hi,
                q_data.tu, q_data.tv, q_data.tu, ZERO_Q16, 1'b0};
        if (q_data.inner_h) kind_nxt = nsrl_pkg::K_CE;
        else last = 1'b1;
      end
      nsrl_pkg::K_CE: begin
        quad = {q_data.x_a, q_data.y_a, q_data.x_b, q_data.y_b,
                q_data.tu, q_data.tv, q_data.tu, q_data.tv, 1'b0};
        last = 1'b1;
      end
      default: last = 1'b1;
    endcase
    quad.last_quad = last;
    if (last) kind_nxt = nsrl_pkg::K_BL;
    if (!advance) kind_nxt = kind_r;
  end

  assign q_pop = advance && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= nsrl_pkg::K_BL;
      valid_r <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      if (advance) begin
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quad_r <= quad;
    end
  end

  assign empty    = !valid_r;
  assign out_quad = quad_r;

endmodule

/* rtl/core/nine_slice_rect_layout_top.sv */
// channel  | ports                         | accepted when
// ---------+-------------------------------+------------------------------
// box in   | push, full, in_box            | push && !full
// quad out | empty, pop, out_quad          | pop && !empty
// config   | cfg_we, cfg_idx, cfg_data     | cfg_we
//
// an accepted box goes straight into the classify queue; the quad sequencer emits one quad
// per cycle while a box waits and the receiver keeps popping, four to nine quads per box
// after reset and after each register write, full stays high while the
// shared serial divider computes both corner extents (24 steps per axis)
// either side may stall freely; the queue and the output register decouple them
module nine_slice_rect_layout_top #(
  parameter int QUEUE_DEPTH = nsrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  nsrl_pkg::box_t                 in_box,
  output logic                           empty,
  input  logic                           pop,
  output nsrl_pkg::quad_t                out_quad,
  input  logic                           cfg_we,
  input  logic [nsrl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [nsrl_pkg::CFG_W-1:0]     cfg_data
);

  nsrl_pkg::div_req_t div_req;
  nsrl_pkg::div_rsp_t div_rsp;
  nsrl_pkg::split_t   q_wr_data, q_rd_data;
  logic               q_push, q_full, q_pop, q_empty;

  nsrl_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  nsrl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_box   (in_box),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (q_wr_data)
  );

  nsrl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  nsrl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rd_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_quad (out_quad)
  );

endmodule

/* rtl/core/nsrl_checker.sv */
module nsrl_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            full,
  input logic            empty,
  input logic            pop,
  input nsrl_pkg::quad_t out_quad,
  input logic            cfg_we
);

  // extents are rebuilt after reset, so no box may enter right away
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> full)
    else $error("input not blocked after reset");

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_full_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> full)
    else $error("input not blocked during extent update");

  // quads of one box come back to back once the first is taken
  a_box_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_quad.last_quad) |=> !empty)
    else $error("gap inside one box's quads");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_quad)))
    else $error("stalled result changed");

endmodule

bind nine_slice_rect_layout_top nsrl_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_quad (out_quad),
  .cfg_we   (cfg_we)
);

/* bench/nine_slice_rect_layout_top_tb.sv */
`timescale 1ns / 1ps

module nine_slice_rect_layout_top_tb;
  import nsrl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = CFG_IDX_W'(7);
  localparam longint COORD_MAX = 64'sd8388607;
  localparam longint COORD_MIN = -64'sd8388608;

  typedef struct {
    box_t  bx;
    bit    typed;
    quad_t bl;
    int    count;
  } probe_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  box_t                 in_box;
  logic                 empty;
  logic                 pop = 1'b0;
  quad_t                out_quad;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  // register shadow used by the layout predictor
  logic [TEX_W-1:0]    cur_center_x;
  logic [TEX_W-1:0]    cur_center_y;
  logic [CORNER_W-1:0] cur_corner_x;
  logic [CORNER_W-1:0] cur_corner_y;
  logic [TSIZE_W-1:0]  cur_tex_w;
  logic [TSIZE_W-1:0]  cur_tex_h;

  quad_t  pending_quads[$];
  probe_t probe_tab[$];

  int  mismatches = 0;
  int  boxes_sent = 0;
  int  quads_checked = 0;
  int  settings_applied = 0;
  int  phase_no = 0;
  int  corners_only = 0;
  int  one_axis = 0;
  int  full_nine = 0;
  int  hold_left = 0;
  int  roll;
  bit  held_off = 0;
  bit  draining = 0;
  bit  steady = 0;

  nine_slice_rect_layout_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_box   (in_box),
    .empty    (empty),
    .pop      (pop),
    .out_quad (out_quad),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [TEX_W-1:0] clamp_center(input logic [TEX_W-1:0] c);
    return (c > ONE_Q16) ? ONE_Q16 : c;
  endfunction

  function automatic longint corner_extent(input logic [TSIZE_W-1:0] px,
                                           input logic [CORNER_W-1:0] corner,
                                           input logic [TEX_W-1:0] c);
    longint m;
    if (corner == 0) begin
      return longint'(px) * 256;
    end
    m = (c > HALF_Q16) ? longint'(c) : 65536 - longint'(c);
    return (longint'(corner) * 65536) / m;
  endfunction

  // stripes meet at the box middle when the extent does not fit
  function automatic bit split_span(input longint lo, input longint hi, input longint ext,
                                    output longint a, output longint b);
    if (ext > hi - lo) begin
      a = (lo + hi) >>> 1;
      b = a;
      return 1'b0;
    end
    a = lo + (ext >>> 1);
    b = hi - (ext >>> 1);
    return 1'b1;
  endfunction

  function automatic quad_t make_quad(input longint x0, input longint y0,
                                      input longint x1, input longint y1,
                                      input logic [TEX_W-1:0] u0, input logic [TEX_W-1:0] v0,
                                      input logic [TEX_W-1:0] u1, input logic [TEX_W-1:0] v1);
    quad_t q;
    q.quad_x0   = COORD_W'(x0);
    q.quad_y0   = COORD_W'(y0);
    q.quad_x1   = COORD_W'(x1);
    q.quad_y1   = COORD_W'(y1);
    q.tex_u0    = u0;
    q.tex_v0    = v0;
    q.tex_u1    = u1;
    q.tex_v1    = v1;
    q.last_quad = 1'b0;
    return q;
  endfunction

  function automatic box_t make_box(input longint l, input longint bo,
                                    input longint r, input longint t);
    box_t bx;
    bx.box_left   = COORD_W'(l);
    bx.box_bottom = COORD_W'(bo);
    bx.box_right  = COORD_W'(r);
    bx.box_top    = COORD_W'(t);
    return bx;
  endfunction

  // appends the quads of one box to pending_quads, returns how many
  function automatic int layout_quads(input box_t bx);
    longint l, bo, r, t, lm, rm, bm, tm;
    logic [TEX_W-1:0] cx, cy, tu, tv;
    bit in_h, in_v;
    quad_t qs[$];
    quad_t q;
    cx = clamp_center(cur_center_x);
    cy = clamp_center(cur_center_y);
    tu = cx;
    tv = ONE_Q16 - cy;
    l  = $signed(bx.box_left);
    bo = $signed(bx.box_bottom);
    r  = $signed(bx.box_right);
    t  = $signed(bx.box_top);
    in_h = split_span(bo, t, corner_extent(cur_tex_h, cur_corner_y, cy), bm, tm);
    in_v = split_span(l, r, corner_extent(cur_tex_w, cur_corner_x, cx), lm, rm);
    qs.push_back(make_quad(l, bo, lm, bm, 0, ONE_Q16, tu, tv));
    qs.push_back(make_quad(l, tm, lm, t, 0, tv, tu, 0));
    qs.push_back(make_quad(rm, tm, r, t, tu, tv, ONE_Q16, 0));
    qs.push_back(make_quad(rm, bo, r, bm, tu, ONE_Q16, ONE_Q16, tv));
    if (in_h) begin
      qs.push_back(make_quad(l, bm, lm, tm, 0, tv, tu, tv));
      qs.push_back(make_quad(rm, bm, r, tm, tu, tv, ONE_Q16, tv));
    end
    if (in_v) begin
      qs.push_back(make_quad(lm, bo, rm, bm, tu, ONE_Q16, tu, tv));
      qs.push_back(make_quad(lm, tm, rm, t, tu, tv, tu, 0));
    end
    if (in_h && in_v) begin
      qs.push_back(make_quad(lm, bm, rm, tm, tu, tv, tu, tv));
    end
    q = qs.pop_back();
    q.last_quad = 1'b1;
    qs.push_back(q);
    foreach (qs[i]) pending_quads.push_back(qs[i]);
    if (qs.size() == 4) corners_only++;
    else if (qs.size() == 9) full_nine++;
    else one_axis++;
    return qs.size();
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // box spans cluster around the corner extent so both split outcomes show up
  function automatic longint pick_span(input longint ext);
    case ($urandom_range(0, 5))
      0: return ext;
      1: return ext - 1;
      2: return ext + 1;
      3: return longint'($urandom_range(0, 32'(2 * ext + 2)));
      4: return -longint'($urandom_range(0, 5000));
      default: return longint'($urandom_range(0, 16777215));
    endcase
  endfunction

  function automatic box_t random_box();
    longint ex, ey, l, bo;
    box_t bx;
    if ($urandom_range(0, 7) == 0) begin
      bx = {$urandom(), $urandom(), $urandom()};
      return bx;
    end
    ex = corner_extent(cur_tex_w, cur_corner_x, clamp_center(cur_center_x));
    ey = corner_extent(cur_tex_h, cur_corner_y, clamp_center(cur_center_y));
    l  = longint'($urandom_range(0, 8388607)) - 4194304;
    bo = longint'($urandom_range(0, 8388607)) - 4194304;
    return make_box(l, bo, clamp_coord(l + pick_span(ex)), clamp_coord(bo + pick_span(ey)));
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_W-1:0] rand_center();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 8388607));
      1: return '0;
      2: return CFG_W'(65536);
      3: return CFG_W'(32768);
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_corner();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return '0;
    if (r == 5) return CFG_W'($urandom_range(1, 8388607));
    return CFG_W'($urandom_range(1, 60000));
  endfunction

  function automatic logic [CFG_W-1:0] rand_tsize();
    if ($urandom_range(0, 7) == 0) return CFG_W'(8192);
    return CFG_W'($urandom_range(1, 400));
  endfunction

  function automatic void add_row(input box_t bx, input bit typed, input quad_t bl,
                                  input int count);
    probe_t p;
    p.bx    = bx;
    p.typed = typed;
    p.bl    = bl;
    p.count = count;
    probe_tab.push_back(p);
  endfunction

  task automatic check_quad(input quad_t got);
    quad_t want;
    if (pending_quads.size() == 0) begin
      $display("%0t: quad with no box behind it: expected none, got %p", $time, got);
      mismatches++;
    end else begin
      want = pending_quads.pop_front();
      if (got.quad_x0 !== want.quad_x0)
        $display("%0t: quad_x0 expected %0d got %0d", $time, want.quad_x0, got.quad_x0);
      if (got.quad_y0 !== want.quad_y0)
        $display("%0t: quad_y0 expected %0d got %0d", $time, want.quad_y0, got.quad_y0);
      if (got.quad_x1 !== want.quad_x1)
        $display("%0t: quad_x1 expected %0d got %0d", $time, want.quad_x1, got.quad_x1);
      if (got.quad_y1 !== want.quad_y1)
        $display("%0t: quad_y1 expected %0d got %0d", $time, want.quad_y1, got.quad_y1);
      if (got.tex_u0 !== want.tex_u0)
        $display("%0t: tex_u0 expected %0d got %0d", $time, want.tex_u0, got.tex_u0);
      if (got.tex_v0 !== want.tex_v0)
        $display("%0t: tex_v0 expected %0d got %0d", $time, want.tex_v0, got.tex_v0);
      if (got.tex_u1 !== want.tex_u1)
        $display("%0t: tex_u1 expected %0d got %0d", $time, want.tex_u1, got.tex_u1);
      if (got.tex_v1 !== want.tex_v1)
        $display("%0t: tex_v1 expected %0d got %0d", $time, want.tex_v1, got.tex_v1);
      if (got.last_quad !== want.last_quad)
        $display("%0t: last_quad expected %0b got %0b", $time, want.last_quad, got.last_quad);
      if (got !== want) mismatches++;
    end
  endtask

  // quad receiver: random stalls, one long hold-off so the box queue backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_quad(out_quad);
        quads_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held_off && quads_checked >= 200) begin
        held_off = 1'b1;
        hold_left = 400;
        pop <= 1'b0;
      end else if (draining || quads_checked % 256 < 64) begin
        pop <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          pop <= 1'b1;
        end else if (roll < 92) begin
          pop <= 1'b0;
          hold_left = $urandom_range(0, 2);
        end else begin
          pop <= 1'b0;
          hold_left = $urandom_range(8, 40);
        end
      end
    end
  end

  // push stays high across back-to-back requests
  task automatic send_box(input box_t bx);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push   <= 1'b1;
    in_box <= bx;
    @(posedge clk);
    while (full) @(posedge clk);
    boxes_sent++;
  endtask

  task automatic finish_phase();
    push <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    case (idx)
      REG_CENTER_X:   cur_center_x = d[TEX_W-1:0];
      REG_CENTER_Y:   cur_center_y = d[TEX_W-1:0];
      REG_CORNER_X:   cur_corner_x = d[CORNER_W-1:0];
      REG_CORNER_Y:   cur_corner_y = d[CORNER_W-1:0];
      REG_TEX_WIDTH:  cur_tex_w = d[TSIZE_W-1:0];
      REG_TEX_HEIGHT: cur_tex_h = d[TSIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                               input logic [CFG_W-1:0] csx, input logic [CFG_W-1:0] csy,
                               input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th,
                               input bit stray);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CORNER_X, csx);
    cfg_write(REG_CORNER_Y, csy);
    cfg_write(REG_TEX_WIDTH, tw);
    cfg_write(REG_TEX_HEIGHT, th);
    if (stray) begin
      // unmapped indexes must leave every register alone
      cfg_write(REG_SPARE_6, CFG_W'($urandom()));
      cfg_write(REG_SPARE_7, CFG_W'($urandom()));
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_phase(input int count);
    box_t bx;
    steady = (phase_no % 3 == 2);
    repeat (count) begin
      bx = random_box();
      send_box(bx);
      void'(layout_quads(bx));
    end
    finish_phase();
    phase_no++;
  endtask

  initial begin : stimulus
    int n;
    rst_n    = 1'b0;
    push     = 1'b0;
    in_box   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    cur_center_x = CENTER_RST;
    cur_center_y = CENTER_RST;
    cur_corner_x = '0;
    cur_corner_y = '0;
    cur_tex_w    = TSIZE_RST;
    cur_tex_h    = TSIZE_RST;

    // reset values give a 16384 extent on both axes
    add_row(make_box(0, 0, 65536, 65536), 1,
            make_quad(0, 0, 8192, 8192, 0, 65536, 32768, 32768), 9);
    add_row(make_box(0, 0, 16384, 16384), 1,
            make_quad(0, 0, 8192, 8192, 0, 65536, 32768, 32768), 9);
    add_row(make_box(0, 0, 16383, 16383), 1,
            make_quad(0, 0, 8191, 8191, 0, 65536, 32768, 32768), 4);
    add_row(make_box(100, 100, -100, -100), 1,
            make_quad(100, 100, 0, 0, 0, 65536, 32768, 32768), 4);
    add_row(make_box(0, 0, 0, 0), 1,
            make_quad(0, 0, 0, 0, 0, 65536, 32768, 32768), 4);
    add_row(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX), 1,
            make_quad(COORD_MIN, COORD_MIN, -8380416, -8380416, 0, 65536, 32768, 32768), 9);
    add_row(make_box(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN), 1,
            make_quad(COORD_MAX, COORD_MAX, -1, -1, 0, 65536, 32768, 32768), 4);
    add_row(make_box(0, 0, 65536, 100), 0, '0, 0);
    add_row(make_box(0, 0, 100, 65536), 0, '0, 0);
    add_row(make_box(-1, -1, -1, -1), 0, '0, 0);
    add_row(make_box(5592405, -5592406, -5592406, 5592405), 0, '0, 0);
    add_row(make_box(-5592406, 5592405, 5592405, -5592406), 0, '0, 0);
    add_row(make_box(COORD_MIN, 0, COORD_MAX, 0), 0, '0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_tab[i]) begin
      send_box(probe_tab[i].bx);
      n = layout_quads(probe_tab[i].bx);
      if (probe_tab[i].typed) begin
        pending_quads[pending_quads.size() - n] = probe_tab[i].bl;
        if (n != probe_tab[i].count) begin
          $display("%0t: quad count for box %p expected %0d got %0d", $time,
                   probe_tab[i].bx, probe_tab[i].count, n);
          mismatches++;
        end
      end
    end
    random_phase(45);

    // zero texture size, centers at the ends of their range
    apply_setting(0, 65536, 0, 0, 0, 0, 1'b0);
    random_phase(45);
    // largest corner sizes, 8192-pixel textures
    apply_setting(65536, 0, 8388607, 8388607, 8192, 8192, 1'b0);
    random_phase(45);
    // center above one, small corner sizes, one-pixel textures, writes to unmapped indexes
    apply_setting(CFG_W'(8388607), 32769, 1, 256, 1, 1, 1'b1);
    random_phase(45);
    repeat (5) begin
      apply_setting(rand_center(), rand_center(), rand_corner(), rand_corner(),
                    rand_tsize(), rand_tsize(), $urandom_range(0, 1));
      random_phase(45);
    end

    draining = 1'b1;
    repeat (60) @(posedge clk);
    $display("%0d boxes over %0d register settings, %0d quads checked",
             boxes_sent, settings_applied + 1, quads_checked);
    $display("boxes split: %0d corners only, %0d one inner axis, %0d all nine quads",
             corners_only, one_axis, full_nine);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
